FILE: rtl/iqs_pkg.sv
package iqs_pkg;

   localparam int DATA_W      = 32;
   localparam int FIELD_W     = 8;
   localparam int QUEUE_DEPTH = 128;
   localparam int QPTR_W      = 7;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
   } rsp_type;

   // queued range: first index and one past the last index
   typedef struct packed {
      logic [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0] hb;
   } range_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_Q_CHECK,
      ST_Q_LOAD,
      ST_PIV_RD,
      ST_PIV_LD,
      ST_P_RD,
      ST_P_CMP,
      ST_P_WR,
      ST_F_RD,
      ST_F_HI,
      ST_F_LO,
      ST_F_PUSH,
      ST_E_RD,
      ST_E_LD,
      ST_E_WAIT
   } state_type;

   typedef struct packed {
      logic load_item;     // store incoming value at the fill index
      logic q_seed;        // queue the whole set, rewind pointers
      logic q_pop;         // read the queue head
      logic range_load;    // take lo/hi from the popped range
      logic rd_pivot;      // read element at hi
      logic pivot_load;    // latch pivot
      logic rd_pair;       // read elements at j and i
      logic swap_lo;       // element[i] <= element[j]
      logic swap_hi;       // element[j] <= old element[i], advance i and j
      logic j_step;        // advance j only
      logic rd_split;      // read element at i
      logic put_hi;        // element[hi] <= element[i]
      logic put_lo;        // element[i] <= pivot, queue lower range
      logic push_upper;    // queue upper range
      logic emit_rd;       // read element at k
      logic out_load;      // load output register
      logic emit_next;     // advance k
      logic emit_done;     // empty the store
   } cmd_type;

   typedef struct packed {
      logic queue_empty;
      logic range_ok;
      logic j_at_hi;
      logic le_pivot;
      logic out_last;
   } status_type;

endpackage

FILE: rtl/iqs_ctrl.sv
module iqs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  iqs_pkg::status_type status,
   output iqs_pkg::cmd_type    cmd
);

   iqs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iqs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         iqs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (req_last) begin
                  state_in = iqs_pkg::ST_INIT;
               end
            end
         end
         iqs_pkg::ST_INIT: begin
            cmd.q_seed = 1'b1;
            state_in   = iqs_pkg::ST_Q_CHECK;
         end
         iqs_pkg::ST_Q_CHECK: begin
            if (status.queue_empty) begin
               state_in = iqs_pkg::ST_E_RD;
            end else begin
               cmd.q_pop = 1'b1;
               state_in  = iqs_pkg::ST_Q_LOAD;
            end
         end
         iqs_pkg::ST_Q_LOAD: begin
            cmd.range_load = 1'b1;
            state_in = status.range_ok ? iqs_pkg::ST_PIV_RD : iqs_pkg::ST_Q_CHECK;
         end
         iqs_pkg::ST_PIV_RD: begin
            cmd.rd_pivot = 1'b1;
            state_in     = iqs_pkg::ST_PIV_LD;
         end
         iqs_pkg::ST_PIV_LD: begin
            cmd.pivot_load = 1'b1;
            state_in       = iqs_pkg::ST_P_RD;
         end
         iqs_pkg::ST_P_RD: begin
            if (status.j_at_hi) begin
               state_in = iqs_pkg::ST_F_RD;
            end else begin
               cmd.rd_pair = 1'b1;
               state_in    = iqs_pkg::ST_P_CMP;
            end
         end
         iqs_pkg::ST_P_CMP: begin
            if (status.le_pivot) begin
               cmd.swap_lo = 1'b1;
               state_in    = iqs_pkg::ST_P_WR;
            end else begin
               cmd.j_step = 1'b1;
               state_in   = iqs_pkg::ST_P_RD;
            end
         end
         iqs_pkg::ST_P_WR: begin
            cmd.swap_hi = 1'b1;
            state_in    = iqs_pkg::ST_P_RD;
         end
         iqs_pkg::ST_F_RD: begin
            cmd.rd_split = 1'b1;
            state_in     = iqs_pkg::ST_F_HI;
         end
         iqs_pkg::ST_F_HI: begin
            cmd.put_hi = 1'b1;
            state_in   = iqs_pkg::ST_F_LO;
         end
         iqs_pkg::ST_F_LO: begin
            cmd.put_lo = 1'b1;
            state_in   = iqs_pkg::ST_F_PUSH;
         end
         iqs_pkg::ST_F_PUSH: begin
            cmd.push_upper = 1'b1;
            state_in       = iqs_pkg::ST_Q_CHECK;
         end
         iqs_pkg::ST_E_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = iqs_pkg::ST_E_LD;
         end
         iqs_pkg::ST_E_LD: begin
            cmd.out_load = 1'b1;
            state_in     = iqs_pkg::ST_E_WAIT;
         end
         iqs_pkg::ST_E_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.out_last) begin
                  cmd.emit_done = 1'b1;
                  state_in      = iqs_pkg::ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = iqs_pkg::ST_E_RD;
               end
            end
         end
         default: begin
            state_in = iqs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/iqs_datapath.sv
module iqs_datapath #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  iqs_pkg::req_type    req_data,
   output iqs_pkg::rsp_type    rsp_data,
   input  iqs_pkg::cmd_type    cmd,
   output iqs_pkg::status_type status
);

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int FW    = iqs_pkg::FIELD_W;

   logic [iqs_pkg::DATA_W-1:0] elem_mem_ff [MAX_ELEMENTS];
   iqs_pkg::range_type         queue_mem_ff [iqs_pkg::QUEUE_DEPTH];

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [iqs_pkg::QPTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0]            lo_ff, hi_ff, i_ff, j_ff, k_ff;
   logic [IDX_W-1:0]            lo_in, hi_in, i_in, j_in, k_in;
   logic [iqs_pkg::DATA_W-1:0]  pivot_ff, rd_a_ff, rd_b_ff;
   iqs_pkg::range_type          q_rd_ff;
   iqs_pkg::rsp_type            rsp_ff;

   logic                        room;
   logic                        st_we;
   logic [IDX_W-1:0]            st_waddr;
   logic [iqs_pkg::DATA_W-1:0]  st_wdata;
   logic                        rd_a_en;
   logic [IDX_W-1:0]            rd_a_addr;
   logic                        q_we;
   logic [iqs_pkg::QPTR_W-1:0]  q_waddr;
   iqs_pkg::range_type          q_wdata;

   assign room = count_ff < CNT_W'(MAX_ELEMENTS);

   // element store write port
   always_comb begin
      st_we    = 1'b0;
      st_waddr = i_ff;
      st_wdata = rd_a_ff;
      if (cmd.load_item) begin
         st_we    = room;
         st_waddr = count_ff[IDX_W-1:0];
         st_wdata = req_data.value;
      end else if (cmd.swap_lo) begin
         st_we = 1'b1;
      end else if (cmd.swap_hi) begin
         st_we    = 1'b1;
         st_waddr = j_ff;
         st_wdata = rd_b_ff;
      end else if (cmd.put_hi) begin
         st_we    = 1'b1;
         st_waddr = hi_ff;
      end else if (cmd.put_lo) begin
         st_we    = 1'b1;
         st_wdata = pivot_ff;
      end
   end

   // element store read port A
   always_comb begin
      rd_a_en   = cmd.rd_pivot | cmd.rd_pair | cmd.rd_split | cmd.emit_rd;
      rd_a_addr = k_ff;
      if (cmd.rd_pivot) begin
         rd_a_addr = hi_ff;
      end else if (cmd.rd_pair) begin
         rd_a_addr = j_ff;
      end else if (cmd.rd_split) begin
         rd_a_addr = i_ff;
      end
   end

   // range queue write port
   always_comb begin
      q_we    = cmd.q_seed | cmd.put_lo | cmd.push_upper;
      q_waddr = tail_ff;
      q_wdata = '{lo: FW'(i_ff) + FW'(1), hb: FW'(hi_ff) + FW'(1)};
      if (cmd.q_seed) begin
         q_waddr = '0;
         q_wdata = '{lo: '0, hb: FW'(count_ff)};
      end else if (cmd.put_lo) begin
         q_wdata = '{lo: FW'(lo_ff), hb: FW'(i_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         elem_mem_ff[st_waddr] <= st_wdata;
      end
      if (rd_a_en) begin
         rd_a_ff <= elem_mem_ff[rd_a_addr];
      end
      if (cmd.rd_pair) begin
         rd_b_ff <= elem_mem_ff[i_ff];
      end
      if (q_we) begin
         queue_mem_ff[q_waddr] <= q_wdata;
      end
      if (cmd.q_pop) begin
         q_rd_ff <= queue_mem_ff[head_ff];
      end
   end

   // index and counter updates
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      if (cmd.load_item && room) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.emit_done) begin
         count_in = '0;
      end
      if (cmd.q_seed) begin
         head_in = '0;
         tail_in = iqs_pkg::QPTR_W'(1);
         k_in    = '0;
      end
      if (cmd.put_lo || cmd.push_upper) begin
         tail_in = tail_ff + iqs_pkg::QPTR_W'(1);
      end
      if (cmd.q_pop) begin
         head_in = head_ff + iqs_pkg::QPTR_W'(1);
      end
      if (cmd.range_load) begin
         lo_in = q_rd_ff.lo[IDX_W-1:0];
         hi_in = IDX_W'(q_rd_ff.hb - FW'(1));
         i_in  = q_rd_ff.lo[IDX_W-1:0];
         j_in  = q_rd_ff.lo[IDX_W-1:0];
      end
      if (cmd.swap_hi) begin
         i_in = i_ff + IDX_W'(1);
         j_in = j_ff + IDX_W'(1);
      end
      if (cmd.j_step) begin
         j_in = j_ff + IDX_W'(1);
      end
      if (cmd.emit_next) begin
         k_in = k_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      if (cmd.pivot_load) begin
         pivot_ff <= rd_a_ff;
      end
      if (cmd.out_load) begin
         rsp_ff.sorted_value <= rd_a_ff;
         rsp_ff.last_out     <= (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;
      end
   end

   assign status.queue_empty = head_ff == tail_ff;
   assign status.range_ok    = ({1'b0, q_rd_ff.lo} + (FW + 1)'(1)) < {1'b0, q_rd_ff.hb};
   assign status.j_at_hi     = j_ff == hi_ff;
   assign status.le_pivot    = $signed(rd_a_ff) <= $signed(pivot_ff);
   assign status.out_last    = rsp_ff.last_out;

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/iterative_quicksort_engine.sv
// Sorting engine for sets of up to MAX_ELEMENTS signed 32-bit values.
// Request channel (req_valid/req_ready/req_data): one value per transaction;
// is_last marks the final value of a set and starts the sort. Values beyond
// MAX_ELEMENTS are dropped, but an is_last on such a transaction still sorts.
// Response channel (rsp_valid/rsp_ready/rsp_data): after the sort, one
// transaction per stored value in ascending order, last_out set on the final.
// Loading accepts one value per cycle. The sort is an iterative quicksort with a
// range FIFO and Lomuto partitioning on a single-write element RAM: each
// partition element is read and compared, and written back when it moves;
// each popped range is loaded and checked, and each range that gets split also
// takes a pivot fetch, a final compare step, pivot placement and an upper push.
// Presorted ascending input is a worst case. Each result then goes through a
// RAM read, an output register load and a handshake, and a receiver stall
// holds it in the handshake.
// While sorting or emitting, req_ready stays low; a stalled receiver simply
// holds the engine in its output state with the payload frozen.
// Reset empties the store and returns to idle; RAM contents are not cleared.
module iterative_quicksort_engine #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iqs_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   iqs_pkg::cmd_type    cmd;
   iqs_pkg::status_type status;

   // sequencer: load, partition loop, emit
   iqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.is_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // element RAM, range FIFO RAM, indices and output register
   iqs_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

FILE: rtl/iqs_checker.sv
module iqs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input iqs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input iqs_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // never loading and emitting at once
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready and result valid together");

   // the final value of a set closes the input side
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.is_last |=> !req_ready)
      else $error("input open after last value");

   // the final result ends the emit phase
   a_last_out_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_out |=> !rsp_valid)
      else $error("result after last_out");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind iterative_quicksort_engine iqs_checker u_iqs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
